// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rle frame renderer, included by its datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, uses clk and rst_n of the enclosing module
`define RFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfr assertion failed");

// next-cycle implication, uses clk and rst_n of the enclosing module
`define RFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfr assertion failed");

`endif

// ----- hw/rtl/rfr_pkg.sv -----
// types and constants of the rle frame renderer
package rfr_pkg;

    localparam int ADDR_W      = 10;
    localparam int COUNT_W     = 14;
    localparam int RUN_W       = 15;
    localparam int MAX_RESULTS = 32;

    // request codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // escape bytes
    localparam logic [7:0] ESC_DARK  = 8'h55;
    localparam logic [7:0] ESC_LIGHT = 8'haa;

    // hue wheel
    localparam logic [10:0] HUE_STEP   = 11'd6;
    localparam logic [10:0] HUE_PERIOD = 11'd768;

    // reciprocals: ceil(2^24/50) and ceil(2^24/255)
    localparam logic [18:0] RECIP_50  = 19'd335545;
    localparam logic [16:0] RECIP_255 = 17'd65794;
    localparam logic [7:0]  LED_MAX   = 8'd255;

    typedef struct packed {
        logic                cmd;
        logic [7:0]          stream_byte;
        logic [ADDR_W-1:0]   read_address;
    } in_item_t;

    typedef struct packed {
        logic                result_kind;
        logic [7:0]          read_byte;
        logic [COUNT_W-1:0]  pixel_count;
        logic [COUNT_W-1:0]  motion;
        logic [7:0]          led_red;
        logic [7:0]          led_green;
        logic [7:0]          led_blue;
        logic                last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic rmw;
        logic advance;
        logic fin1;
        logic fin2;
        logic fin3;
        logic fin4;
        logic fin5;
        logic hold;
        logic wipe;
        logic wipe_all;
        logic flush;
        logic rd_shown;
        logic send_read;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic draw_start;
        logic bit_set;
        logic frame_end;
        logic item_done;
        logic more;
        logic hold_ok;
        logic wipe_done;
        logic out_free;
        logic held_valid;
    } dp_status_t;

endpackage

// ----- hw/rtl/rfr_ram.sv -----
// generic single write port ram with registered read
module rfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/rfr_ctrl.sv -----
// sequencing state machine of the rle frame renderer
module rfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output rfr_pkg::ctl_cmd_t  ctl,
    input  rfr_pkg::dp_status_t sts
);
    import rfr_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_BIT    = 4'd3;
    localparam logic [3:0] S_RMW    = 4'd4;
    localparam logic [3:0] S_FIN1   = 4'd5;
    localparam logic [3:0] S_FIN2   = 4'd6;
    localparam logic [3:0] S_FIN3   = 4'd7;
    localparam logic [3:0] S_FIN4   = 4'd8;
    localparam logic [3:0] S_FIN5   = 4'd9;
    localparam logic [3:0] S_HOLD   = 4'd10;
    localparam logic [3:0] S_WIPE   = 4'd11;
    localparam logic [3:0] S_END    = 4'd12;
    localparam logic [3:0] S_RDATA  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] adv_state;

    // where drawing goes after one pixel bit
    always_comb
    begin
        if (sts.frame_end)
        begin
            adv_state = S_FIN1;
        end
        else if (sts.item_done)
        begin
            adv_state = S_END;
        end
        else
        begin
            adv_state = S_BIT;
        end
    end

    // next state and commands
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.wipe     = 1'b1;
                ctl.wipe_all = 1'b1;
                if (sts.wipe_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ctl.load = item_valid;
                if (item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_read)
                begin
                    ctl.rd_shown = 1'b1;
                    state_next   = S_RDATA;
                end
                else
                begin
                    ctl.decode = 1'b1;
                    state_next = sts.draw_start ? S_BIT : S_END;
                end
            end
            S_BIT:
            begin
                if (sts.bit_set)
                begin
                    state_next = S_RMW;
                end
                else
                begin
                    ctl.advance = 1'b1;
                    state_next  = adv_state;
                end
            end
            S_RMW:
            begin
                ctl.rmw     = 1'b1;
                ctl.advance = 1'b1;
                state_next  = adv_state;
            end
            S_FIN1:
            begin
                ctl.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                ctl.fin2   = 1'b1;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                ctl.fin3   = 1'b1;
                state_next = S_FIN4;
            end
            S_FIN4:
            begin
                ctl.fin4   = 1'b1;
                state_next = S_FIN5;
            end
            S_FIN5:
            begin
                ctl.fin5   = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                ctl.hold = 1'b1;
                if (sts.hold_ok)
                begin
                    state_next = S_WIPE;
                end
            end
            S_WIPE:
            begin
                ctl.wipe = 1'b1;
                if (sts.wipe_done)
                begin
                    state_next = sts.more ? S_BIT : S_END;
                end
            end
            S_END:
            begin
                ctl.flush = 1'b1;
                if (!sts.held_valid || sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDATA:
            begin
                ctl.send_read = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);
endmodule

// ----- hw/rtl/rfr_datapath.sv -----
// decoder registers, frame banks, record math and output stage
`include "assert_macros.svh"
module rfr_datapath #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rfr_pkg::in_item_t   item,
    input  rfr_pkg::ctl_cmd_t   ctl,
    output rfr_pkg::dp_status_t sts,
    input  logic                result_ready,
    output logic                result_valid,
    output rfr_pkg::out_item_t  result
);
    import rfr_pkg::*;

    localparam int PAGES = (FRAME_HEIGHT + 7) / 8;
    localparam int BYTES = PAGES * FRAME_WIDTH;
    localparam int AW    = $clog2(BYTES);
    localparam int CLW   = $clog2(FRAME_WIDTH);
    localparam int RW    = $clog2(FRAME_HEIGHT);
    localparam int CW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

    // captured request
    in_item_t in_reg;

    // decoder state
    logic       esc_pend_reg, esc_pend_next;
    logic       esc_aa_reg, esc_aa_next;
    logic       run_pend_reg, run_pend_next;
    logic [6:0] run_low_reg, run_low_next;

    // pixel byte being drawn
    logic [7:0]       pix_reg;
    logic [2:0]       bit_idx_reg;
    logic [RUN_W-1:0] bytes_left_reg;

    // raster position
    logic [CLW-1:0] col_reg;
    logic [RW-1:0]  row_reg;
    logic [AW-1:0]  page_base_reg;

    // frame statistics
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] prev_reg;
    logic [9:0]         hue_reg;
    logic               bank_reg;
    logic [AW-1:0]      wipe_addr_reg;

    // record pipeline
    logic [COUNT_W-1:0] rec_cnt_reg;
    logic [COUNT_W-1:0] delta_reg;
    logic [6:0]         a_reg;
    logic [11:0]        q_reg;
    logic [7:0]         int_reg;
    logic [15:0]        prod_r_reg, prod_g_reg, prod_b_reg;
    logic [7:0]         led_r_reg, led_g_reg, led_b_reg;

    // output side
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t held_reg;
    logic      held_valid_reg;
    logic [5:0] frames_reg;

    // decode comb
    logic [7:0]       c;
    logic [7:0]       fill;
    logic             dec_draw;
    logic [7:0]       dec_pix;
    logic [RUN_W-1:0] dec_len;
    logic [RUN_W-1:0] long_len;

    assign c        = in_reg.stream_byte;
    assign fill     = esc_aa_reg ? 8'hff : 8'h00;
    assign long_len = {c, run_low_reg};

    always_comb
    begin
        dec_draw      = 1'b0;
        dec_pix       = c;
        dec_len       = RUN_W'(1);
        esc_pend_next = esc_pend_reg;
        esc_aa_next   = esc_aa_reg;
        run_pend_next = run_pend_reg;
        run_low_next  = run_low_reg;
        if (!esc_pend_reg)
        begin
            if (c == ESC_DARK || c == ESC_LIGHT)
            begin
                esc_pend_next = 1'b1;
                esc_aa_next   = (c == ESC_LIGHT);
            end
            else
            begin
                dec_draw = 1'b1;
            end
        end
        else if (!run_pend_reg)
        begin
            if (c == 8'h00)
            begin
                dec_draw      = 1'b1;
                dec_pix       = esc_aa_reg ? ESC_LIGHT : ESC_DARK;
                esc_pend_next = 1'b0;
            end
            else if (!c[7])
            begin
                dec_draw      = 1'b1;
                dec_pix       = fill;
                dec_len       = {8'd0, c[6:0]};
                esc_pend_next = 1'b0;
            end
            else
            begin
                run_low_next  = c[6:0];
                run_pend_next = 1'b1;
            end
        end
        else
        begin
            // long run of zero length draws nothing
            dec_draw      = (long_len != '0);
            dec_pix       = fill;
            dec_len       = long_len;
            esc_pend_next = 1'b0;
            run_pend_next = 1'b0;
            run_low_next  = 7'd0;
        end
    end

    // position flags and addresses
    logic          col_last, row_last, frame_end, bit_set, item_done;
    logic [AW-1:0] draw_addr;
    logic [7:0]    mask;

    assign col_last  = (col_reg == CLW'(FRAME_WIDTH - 1));
    assign row_last  = (row_reg == RW'(FRAME_HEIGHT - 1));
    assign frame_end = col_last && row_last;
    assign bit_set   = pix_reg[bit_idx_reg];
    assign item_done = (bit_idx_reg == 3'd0) && (bytes_left_reg == RUN_W'(1));
    assign draw_addr = page_base_reg + AW'(col_reg);
    assign mask      = 8'd1 << row_reg[2:0];

    // frame banks
    logic [CW-1:0] rd_ext;
    logic          rd_in_range;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    wdata, rdata0, rdata1, work_rdata, shown_rdata;
    logic          work_we, we0, we1;

    assign rd_ext      = CW'(in_reg.read_address);
    assign rd_in_range = (rd_ext < CW'(BYTES));
    assign raddr       = (ctl.rd_shown || ctl.send_read) ? rd_ext[AW-1:0] : draw_addr;
    assign waddr       = ctl.wipe ? wipe_addr_reg : draw_addr;
    assign work_rdata  = bank_reg ? rdata1 : rdata0;
    assign shown_rdata = bank_reg ? rdata0 : rdata1;
    assign wdata       = ctl.wipe ? 8'h00 : (work_rdata | mask);
    assign work_we     = ctl.rmw || ctl.wipe;
    assign we0         = ctl.wipe_all || (work_we && !bank_reg);
    assign we1         = ctl.wipe_all || (work_we && bank_reg);

    rfr_ram #(.WIDTH(8), .DEPTH(BYTES)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    rfr_ram #(.WIDTH(8), .DEPTH(BYTES)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // record math comb
    logic [10:0]        hue_sum;
    logic [COUNT_W-1:0] delta;
    logic [19:0]        cnt40;
    logic [17:0]        x9;
    logic [36:0]        q_prod;
    logic [12:0]        int_sum;
    logic [7:0]         base_r, base_g, base_b;
    logic [32:0]        m_r, m_g, m_b;

    assign hue_sum = {1'b0, hue_reg} + HUE_STEP;
    assign delta   = (cnt_reg >= prev_reg) ? (cnt_reg - prev_reg) : (prev_reg - cnt_reg);
    assign cnt40   = {1'b0, cnt_reg, 5'd0} + {3'd0, cnt_reg, 3'd0};
    assign x9      = {1'b0, delta_reg, 3'd0} + {4'd0, delta_reg};
    assign q_prod  = 37'(x9) * 37'(RECIP_50);
    assign int_sum = 13'(a_reg) + 13'(q_reg);
    assign m_r     = 33'(prod_r_reg) * 33'(RECIP_255);
    assign m_g     = 33'(prod_g_reg) * 33'(RECIP_255);
    assign m_b     = 33'(prod_b_reg) * 33'(RECIP_255);

    // hue wheel bases
    always_comb
    begin
        if (hue_reg < 10'd256)
        begin
            base_r = ~hue_reg[7:0];
            base_g = hue_reg[7:0];
            base_b = 8'd0;
        end
        else if (hue_reg < 10'd512)
        begin
            base_r = 8'd0;
            base_g = ~hue_reg[7:0];
            base_b = hue_reg[7:0];
        end
        else
        begin
            base_r = hue_reg[7:0];
            base_g = 8'd0;
            base_b = ~hue_reg[7:0];
        end
    end

    // output staging
    logic      out_free, frames_full, hold_ok;
    out_item_t new_rec, read_rec;

    assign out_free    = !out_valid_reg || result_ready;
    assign frames_full = (frames_reg == 6'(MAX_RESULTS));
    assign hold_ok     = frames_full || !held_valid_reg || out_free;

    always_comb
    begin
        new_rec             = '0;
        new_rec.result_kind = KIND_RECORD;
        new_rec.pixel_count = rec_cnt_reg;
        new_rec.motion      = delta_reg;
        new_rec.led_red     = led_r_reg;
        new_rec.led_green   = led_g_reg;
        new_rec.led_blue    = led_b_reg;
        read_rec             = '0;
        read_rec.result_kind = KIND_READ;
        read_rec.read_byte   = rd_in_range ? shown_rdata : 8'h00;
        read_rec.last        = 1'b1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= item;
        end
        if (ctl.decode && dec_draw)
        begin
            pix_reg <= dec_pix;
        end
        if (ctl.fin1)
        begin
            rec_cnt_reg <= cnt_reg;
            delta_reg   <= delta;
            a_reg       <= cnt40[19:13];
        end
        if (ctl.fin2)
        begin
            q_reg <= q_prod[35:24];
        end
        if (ctl.fin3)
        begin
            int_reg <= (int_sum > 13'(LED_MAX)) ? LED_MAX : int_sum[7:0];
        end
        if (ctl.fin4)
        begin
            prod_r_reg <= 16'(base_r) * 16'(int_reg);
            prod_g_reg <= 16'(base_g) * 16'(int_reg);
            prod_b_reg <= 16'(base_b) * 16'(int_reg);
        end
        if (ctl.fin5)
        begin
            led_r_reg <= m_r[31:24];
            led_g_reg <= m_g[31:24];
            led_b_reg <= m_b[31:24];
        end
        if (ctl.send_read && out_free)
        begin
            out_reg <= read_rec;
        end
        else if (ctl.flush && held_valid_reg && out_free)
        begin
            out_reg      <= held_reg;
            out_reg.last <= 1'b1;
        end
        else if (ctl.hold && !frames_full && held_valid_reg && out_free)
        begin
            out_reg <= held_reg;
        end
        if (ctl.hold && hold_ok && !frames_full)
        begin
            held_reg <= new_rec;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pend_reg   <= 1'b0;
            esc_aa_reg     <= 1'b0;
            run_pend_reg   <= 1'b0;
            run_low_reg    <= 7'd0;
            bit_idx_reg    <= 3'd7;
            bytes_left_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            page_base_reg  <= '0;
            cnt_reg        <= '0;
            prev_reg       <= '0;
            hue_reg        <= 10'd0;
            bank_reg       <= 1'b0;
            wipe_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            frames_reg     <= 6'd0;
        end
        else
        begin
            // decoder
            if (ctl.decode)
            begin
                esc_pend_reg <= esc_pend_next;
                esc_aa_reg   <= esc_aa_next;
                run_pend_reg <= run_pend_next;
                run_low_reg  <= run_low_next;
                if (dec_draw)
                begin
                    bit_idx_reg    <= 3'd7;
                    bytes_left_reg <= dec_len;
                end
            end
            // raster advance by one pixel
            if (ctl.advance)
            begin
                if (bit_idx_reg == 3'd0)
                begin
                    bit_idx_reg    <= 3'd7;
                    bytes_left_reg <= bytes_left_reg - RUN_W'(1);
                end
                else
                begin
                    bit_idx_reg <= bit_idx_reg - 3'd1;
                end
                if (col_last)
                begin
                    col_reg <= '0;
                    if (row_last)
                    begin
                        row_reg       <= '0;
                        page_base_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + RW'(1);
                        if (row_reg[2:0] == 3'd7)
                        begin
                            page_base_reg <= page_base_reg + AW'(FRAME_WIDTH);
                        end
                    end
                end
                else
                begin
                    col_reg <= col_reg + CLW'(1);
                end
            end
            // set pixel count
            if (ctl.fin1)
            begin
                cnt_reg  <= '0;
                prev_reg <= cnt_reg;
                hue_reg  <= (hue_sum >= HUE_PERIOD) ? 10'(hue_sum - HUE_PERIOD)
                                                     : hue_sum[9:0];
                bank_reg <= !bank_reg;
            end
            else if (ctl.rmw && cnt_reg != '1)
            begin
                cnt_reg <= cnt_reg + COUNT_W'(1);
            end
            // clearing sweep
            if (ctl.wipe)
            begin
                wipe_addr_reg <= (wipe_addr_reg == AW'(BYTES - 1)) ? '0
                                 : wipe_addr_reg + AW'(1);
            end
            // held record and per-request record count
            if (ctl.load)
            begin
                frames_reg <= 6'd0;
            end
            else if (ctl.hold && hold_ok && !frames_full)
            begin
                held_valid_reg <= 1'b1;
                frames_reg     <= frames_reg + 6'd1;
            end
            else if (ctl.flush && held_valid_reg && out_free)
            begin
                held_valid_reg <= 1'b0;
            end
            // output register
            if ((ctl.send_read && out_free) ||
                (ctl.flush && held_valid_reg && out_free) ||
                (ctl.hold && !frames_full && held_valid_reg && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.is_read    = (in_reg.cmd == CMD_READ);
        sts.draw_start = dec_draw;
        sts.bit_set    = bit_set;
        sts.frame_end  = frame_end;
        sts.item_done  = item_done;
        sts.more       = (bytes_left_reg != '0);
        sts.hold_ok    = hold_ok;
        sts.wipe_done  = (wipe_addr_reg == AW'(BYTES - 1));
        sts.out_free   = out_free;
        sts.held_valid = held_valid_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `RFR_ASSERT_IMP(a_frames_cap, 1'b1, frames_reg <= 6'(MAX_RESULTS))
    `RFR_ASSERT_IMP(a_held_counted, held_valid_reg, frames_reg != 6'd0)
    `RFR_ASSERT_NXT(a_count_cleared, ctl.fin1, cnt_reg == '0)
    `RFR_ASSERT_IMP(a_dual_write, we0 && we1, ctl.wipe_all)
endmodule

// ----- hw/rtl/rle_frame_renderer.sv -----
// top level of the rle frame renderer
//
//  channel   signals                                  payload
//  request   item_valid / item_ready / item           rfr_pkg::in_item_t
//  result    result_valid / result_ready / result     rfr_pkg::out_item_t
//
// a pushed byte passes the accept, decode and end states; in between, each pixel is
// drawn in the bit state and a set pixel adds a read-modify-write on the
// registered-read bank; each completed frame adds the record math (fin1 to fin5)
// plus one clearing sweep of pages*FRAME_WIDTH bytes (1024 by default) over the new
// working bank; a read request passes the accept, decode and read data states
// after reset both banks are swept before any request is taken
// a stalled result waits in the output register while the next request is taken
module rle_frame_renderer #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rfr_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output rfr_pkg::out_item_t  result
);
    import rfr_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t sts;

    rfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .ctl        (ctl),
        .sts        (sts)
    );

    rfr_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .sts          (sts),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

// ----- tb/frame_checker.sv -----
// request/result checker with its own frame renderer predictor
`timescale 1ns / 1ps

module frame_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  rfr_pkg::in_item_t   item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  rfr_pkg::out_item_t  result,
    output int                  errors,
    output int                  pending
);
    import rfr_pkg::*;

    localparam int WIDTH  = 128;
    localparam int HEIGHT = 64;
    localparam int BYTES  = (HEIGHT + 7) / 8 * WIDTH;

    // predicted decoder and frame state
    logic [7:0]  esc_byte;
    logic        in_escape;
    logic [6:0]  long_low;
    logic        in_long_run;
    int          col_pos;
    int          row_pos;
    logic [7:0]  work_bank [BYTES];
    logic [7:0]  shown_bank [BYTES];
    int          last_count;
    int          hue;
    int          records_now;

    out_item_t   expected_results [$];

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // frame done: record, then swap and clear
    function automatic void close_frame();
        int        ones;
        int        delta;
        int        r;
        int        g;
        int        b;
        int        level;
        out_item_t rec;
        ones = 0;
        for (int i = 0; i < BYTES; i++)
            ones += $countones(work_bank[i]);
        if (ones > 16383)
            ones = 16383;
        delta = (ones >= last_count) ? ones - last_count : last_count - ones;
        last_count = ones;
        hue = (hue + 6) % 768;
        if (hue < 256)
        begin
            r = 255 - hue; g = hue; b = 0;
        end
        else if (hue < 512)
        begin
            r = 0; g = 255 - (hue - 256); b = hue - 256;
        end
        else
        begin
            r = hue - 512; g = 0; b = 255 - (hue - 512);
        end
        level = ones * 40 / 8192 + delta * 180 / 1000;
        if (level > 255)
            level = 255;
        if (records_now < MAX_RESULTS)
        begin
            rec = '0;
            rec.result_kind = KIND_RECORD;
            rec.pixel_count = ones[COUNT_W-1:0];
            rec.motion      = delta[COUNT_W-1:0];
            rec.led_red     = 8'(r * level / 255);
            rec.led_green   = 8'(g * level / 255);
            rec.led_blue    = 8'(b * level / 255);
            expected_results.push_back(rec);
            records_now++;
        end
        for (int i = 0; i < BYTES; i++)
        begin
            shown_bank[i] = work_bank[i];
            work_bank[i]  = '0;
        end
    endfunction

    // one pixel byte, msb first in raster order
    function automatic void render_byte(logic [7:0] pix);
        int idx;
        for (int i = 7; i >= 0; i--)
        begin
            if (pix[i])
            begin
                idx = (row_pos / 8) * WIDTH + col_pos;
                if (idx < BYTES)
                    work_bank[idx][row_pos % 8] = 1'b1;
            end
            col_pos++;
            if (col_pos >= WIDTH)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= HEIGHT)
                begin
                    row_pos = 0;
                    close_frame();
                end
            end
        end
    endfunction

    function automatic void render_run(int len);
        logic [7:0] fill;
        fill = (esc_byte == ESC_DARK) ? 8'h00 : 8'hff;
        for (int n = 0; n < len; n++)
            render_byte(fill);
    endfunction

    function automatic void decode_stream_byte(logic [7:0] c);
        if (!in_escape)
        begin
            if (c == ESC_DARK || c == ESC_LIGHT)
            begin
                esc_byte  = c;
                in_escape = 1'b1;
            end
            else
                render_byte(c);
        end
        else if (!in_long_run)
        begin
            if (c == 8'h00)
            begin
                render_byte(esc_byte);
                in_escape = 1'b0;
            end
            else if (!c[7])
            begin
                render_run(int'(c));
                in_escape = 1'b0;
            end
            else
            begin
                long_low    = c[6:0];
                in_long_run = 1'b1;
            end
        end
        else
        begin
            render_run(int'(long_low) | (int'(c) << 7));
            in_escape   = 1'b0;
            in_long_run = 1'b0;
            long_low    = '0;
        end
    endfunction

    // expected results of one accepted request
    function automatic void predict(in_item_t req);
        out_item_t rd;
        int        first;
        first       = expected_results.size();
        records_now = 0;
        if (req.cmd == CMD_READ)
        begin
            rd = '0;
            rd.result_kind = KIND_READ;
            rd.read_byte   = (int'(req.read_address) < BYTES) ? shown_bank[req.read_address]
                                                              : 8'h00;
            expected_results.push_back(rd);
        end
        else
            decode_stream_byte(req.stream_byte);
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    initial
    begin
        errors      = 0;
        pending     = 0;
        esc_byte    = '0;
        in_escape   = 1'b0;
        long_low    = '0;
        in_long_run = 1'b0;
        col_pos     = 0;
        row_pos     = 0;
        last_count  = 0;
        hue         = 0;
        for (int i = 0; i < BYTES; i++)
        begin
            work_bank[i]  = '0;
            shown_bank[i] = '0;
        end
    end

    // compare results, then predict new requests
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report("result with none expected", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.result_kind != want.result_kind)
                        report("result_kind", result.result_kind, want.result_kind);
                    if (result.read_byte != want.read_byte)
                        report("read_byte", result.read_byte, want.read_byte);
                    if (result.pixel_count != want.pixel_count)
                        report("pixel_count", result.pixel_count, want.pixel_count);
                    if (result.motion != want.motion)
                        report("motion", result.motion, want.motion);
                    if (result.led_red != want.led_red)
                        report("led_red", result.led_red, want.led_red);
                    if (result.led_green != want.led_green)
                        report("led_green", result.led_green, want.led_green);
                    if (result.led_blue != want.led_blue)
                        report("led_blue", result.led_blue, want.led_blue);
                    if (result.last != want.last)
                        report("last", result.last, want.last);
                end
            end
            if (item_valid && item_ready)
                predict(item);
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// stimulus, idling and verdict for the rle frame renderer
`timescale 1ns / 1ps

module tb;
    import rfr_pkg::*;

    localparam int QUIET_LIMIT = 150000;
    localparam int HOLD_CYCLES = 600;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    in_item_t   item;
    logic       result_valid;
    logic       result_ready;
    out_item_t  result;
    int         errors;
    int         pending;

    int         send_idle;
    int         recv_idle;
    logic       hold_request;
    int         hold_left;
    int         quiet;
    int         sent;

    rle_frame_renderer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    frame_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // offer one request, with random gaps before it
    task automatic send(in_item_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item       = req;
        do
            @(posedge clk);
        while (!item_ready);
        sent++;
    endtask

    task automatic push(logic [7:0] b);
        in_item_t req;
        req             = '0;
        req.cmd         = CMD_PUSH;
        req.stream_byte = b;
        req.read_address = 10'($urandom);
        send(req);
    endtask

    task automatic read_at(logic [ADDR_W-1:0] a);
        in_item_t req;
        req              = '0;
        req.cmd          = CMD_READ;
        req.read_address = a;
        req.stream_byte  = 8'($urandom);
        send(req);
    endtask

    task automatic maybe_read();
        if ($urandom_range(99) < 20)
            read_at(10'($urandom));
    endtask

    // one well-formed sequence with random content, or noise
    task automatic random_sequence();
        logic [7:0] esc;
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(99);
        esc  = $urandom_range(1) ? ESC_DARK : ESC_LIGHT;
        if (pick < 25)
            read_at(10'($urandom));
        else if (pick < 45)
        begin
            b = 8'($urandom);
            if (b == ESC_DARK || b == ESC_LIGHT)
                b = ~b[0] ? 8'h00 : 8'hff;
            push(b);
        end
        else if (pick < 55)
        begin
            push(esc); maybe_read(); push(8'h00);
        end
        else if (pick < 75)
        begin
            push(esc); maybe_read(); push(8'($urandom_range(127, 1)));
        end
        else if (pick < 90)
        begin
            push(esc); maybe_read();
            push({1'b1, 7'($urandom)}); maybe_read();
            push(8'($urandom_range(10)));
        end
        else
            push(8'($urandom));
    endtask

    // result side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready = 1'b0;
            hold_left    = hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
            result_ready = 1'b0;
        end
        else
            result_ready = ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        quiet        = 0;
        sent         = 0;
        send_idle    = 24;
        recv_idle    = 60;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, escapes, runs, zero-length long run
        read_at(10'd0);
        read_at(10'd1023);
        push(8'hff);
        push(8'h00);
        push(8'h01);
        push(ESC_DARK);  push(8'h00);
        push(ESC_LIGHT); push(8'h00);
        push(ESC_LIGHT); read_at(10'd1); push(8'h7f);
        push(ESC_DARK);  push(8'h80); push(8'h00);
        push(ESC_LIGHT); push(8'h81); push(8'h07);
        read_at(10'h2aa);
        push(ESC_DARK);  push(8'hff); push(8'hff);
        read_at(10'h155);
        read_at(10'd0);

        // sender idles less, receiver more, with a long hold-off
        hold_request = 1'b1;
        for (int n = 0; n < 12; n++)
            read_at(10'($urandom));
        while (sent < 50)
            random_sequence();
        @(negedge clk);
        item_valid = 1'b0;
        wait (pending == 0);

        send_idle = 60;
        recv_idle = 24;
        while (sent < 75)
            random_sequence();

        send_idle = 0;
        recv_idle = 0;
        while (sent < 100)
            random_sequence();

        @(negedge clk);
        item_valid = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
